// File: sv/trp_pkg.sv
// ---------------------------------------------------------------------------
// trp_pkg: shared types and helpers for the trinomial option pricer
// Node record, request and result items, sequencer states and fixed-point
// helpers used by the chain cells, the node datapath and the top level.
// ---------------------------------------------------------------------------
package trp_pkg;

	localparam int MAX_STEPS  = 64;
	localparam int NODES      = 2 * MAX_STEPS + 1;
	localparam int NODE_W     = $clog2(NODES);
	localparam int STEP_W     = $clog2(MAX_STEPS + 1);
	localparam int PIPE_DEPTH = 3;
	localparam int RING_LEN   = NODES + PIPE_DEPTH;
	localparam int POS_W      = $clog2(RING_LEN);
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_STEPS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROB_UP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PROB_MID  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PROB_DOWN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT  = 3'd6;

	typedef struct packed {
		logic        func;
		logic [31:0] spot;
		logic [31:0] strike;
	} req_t;

	typedef struct packed {
		logic [31:0] price;
		logic        overflow;
	} rsp_t;

	typedef struct packed {
		logic [31:0] price;
		logic [31:0] value;
	} node_t;

	typedef struct packed {
		logic en;
		logic act;
		logic root;
	} dp_ctl_t;

	typedef struct packed {
		node_t node;
		logic  ov_hit;
		logic  root_hit;
	} dp_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_DOWN,
		ST_INDUCT,
		ST_DONE
	} state_t;

	// Q16.16 value times Q2.30 factor, truncated; up to 34 significant bits.
	function automatic logic [33:0] mul_q30(input logic [31:0] a, input logic [31:0] f);
		logic [63:0] p;
		p = 64'(a) * 64'(f);
		return p[63:30];
	endfunction

	// Payoff floored at zero: put pays strike minus price, call the reverse.
	function automatic logic [31:0] payoff(input logic is_put, input logic [31:0] s,
		input logic [31:0] k);
		logic [31:0] r;
		r = '0;
		if (is_put) begin
			if (k > s) r = k - s;
		end else begin
			if (s > k) r = s - k;
		end
		return r;
	endfunction

endpackage

// File: sv/trp_cell.sv
// ---------------------------------------------------------------------------
// trp_cell: one lattice node of the rotating chain
// Holds a node's stock price and option value; loads from its neighbor when
// the chain rotates, or from the fill port when addressed.
// ---------------------------------------------------------------------------
module trp_cell
	import trp_pkg::*;
(
	input  logic  clk,
	input  logic  shift,
	input  node_t nxt,
	input  logic  we,
	input  node_t wdata,
	output node_t q
);

	node_t node_q;

	always_ff @(posedge clk) begin
		if (we) begin
			node_q <= wdata;
		end else if (shift) begin
			node_q <= nxt;
		end
	end

	assign q = node_q;

endmodule

// File: sv/trp_datapath.sv
// ---------------------------------------------------------------------------
// trp_datapath: three-stage node update, part of the rotating chain
// Weights the three successors, saturates, discounts and takes the larger of
// continuation and exercise; inactive nodes pass through unchanged.
// ---------------------------------------------------------------------------
module trp_datapath
	import trp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_ctl_t     ctl,
	input  node_t       head,
	input  node_t       upper,
	input  logic        is_put,
	input  logic [31:0] strike,
	input  logic [30:0] prob_up,
	input  logic [30:0] prob_mid,
	input  logic [30:0] prob_down,
	input  logic [30:0] discount,
	output dp_res_t     res
);

	logic [31:0] below_q;

	logic [33:0] t_up_s1, t_mid_s1, t_dn_s1;
	node_t       node_s1, node_s2, node_s3;
	logic        act_s1, act_s2, act_s3;
	logic        root_s1, root_s2, root_s3;
	logic [31:0] sum_s2;
	logic        ov_s2, ov_s3;
	logic [33:0] disc_s3;

	logic [35:0] sum_w;
	logic [31:0] cont;
	logic [31:0] ex;
	logic        ov_disc;

	// The activity and root flags start cleared so that whatever the stages
	// hold before the first sweep passes through as inactive.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1  <= 1'b0;
			act_s2  <= 1'b0;
			act_s3  <= 1'b0;
			root_s1 <= 1'b0;
			root_s2 <= 1'b0;
			root_s3 <= 1'b0;
		end else if (ctl.en) begin
			act_s1  <= ctl.act;
			act_s2  <= act_s1;
			act_s3  <= act_s2;
			root_s1 <= ctl.root;
			root_s2 <= root_s1;
			root_s3 <= root_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			below_q  <= head.value;
			t_up_s1  <= mul_q30(upper.value, {1'b0, prob_up});
			t_mid_s1 <= mul_q30(head.value, {1'b0, prob_mid});
			t_dn_s1  <= mul_q30(below_q, {1'b0, prob_down});
			node_s1  <= head;
		end
	end

	assign sum_w = 36'(t_up_s1) + 36'(t_mid_s1) + 36'(t_dn_s1);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sum_s2  <= (sum_w[35:32] != '0) ? '1 : sum_w[31:0];
			ov_s2   <= sum_w[35:32] != '0;
			node_s2 <= node_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			disc_s3 <= mul_q30(sum_s2, {1'b0, discount});
			ov_s3   <= ov_s2;
			node_s3 <= node_s2;
		end
	end

	assign ov_disc = disc_s3[33:32] != '0;
	assign cont    = ov_disc ? '1 : disc_s3[31:0];
	assign ex      = payoff(is_put, node_s3.price, strike);

	always_comb begin
		res.node.price = node_s3.price;
		res.node.value = node_s3.value;
		if (act_s3) begin
			res.node.value = (ex > cont) ? ex : cont;
		end
		res.ov_hit   = act_s3 & (ov_s3 | ov_disc);
		res.root_hit = act_s3 & root_s3;
	end

endmodule

// File: sv/trinomial_american_option_pricer_unit.sv
// ---------------------------------------------------------------------------
// trinomial_american_option_pricer_unit: American option on a trinomial lattice
// Prices one call or put per item by backward induction over a rotating
// chain of node cells closed through a three-stage node update datapath.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  in        into unit  in_valid/in_ready   req_t  {func, spot, strike}
//  out       from unit  out_valid/out_ready rsp_t  {price, overflow}
//  cfg       into unit  cfg_we              cfg_idx, cfg_wdata
//
// With N the clamped step count, an item fills 2N+1 node cells, then makes
// N rotations of a ring of 129 node cells plus the 3 datapath stages, and
// then hands the result to the output register. The rotation of the chain
// through the single datapath sets the pricing time.
// Reset clears the sequencer, the output register valid, the datapath stage
// flags and the settings to their defaults; the node cells hold no reset
// value and are always filled before use. A stalled output holds its item
// while the next item is taken and priced; that one waits in the done state
// until the register is free.
//
module trinomial_american_option_pricer_unit
	import trp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  req_t                 in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rsp_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_wdata
);

	// Settings registers.
	logic [6:0]  steps_q;
	logic [31:0] up_q;
	logic [30:0] down_q;
	logic [30:0] pu_q;
	logic [30:0] pm_q;
	logic [30:0] pd_q;
	logic [30:0] disc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= 7'(MAX_STEPS);
			up_q    <= 32'd1073741824;
			down_q  <= 31'd1073741824;
			pu_q    <= 31'd357913941;
			pm_q    <= 31'd357913941;
			pd_q    <= 31'd357913941;
			disc_q  <= 31'd1073741824;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_STEPS:     steps_q <= cfg_wdata[6:0];
				REG_UP_FACTOR: up_q    <= cfg_wdata;
				REG_DOWN:      down_q  <= cfg_wdata[30:0];
				REG_PROB_UP:   pu_q    <= cfg_wdata[30:0];
				REG_PROB_MID:  pm_q    <= cfg_wdata[30:0];
				REG_PROB_DOWN: pd_q    <= cfg_wdata[30:0];
				REG_DISCOUNT:  disc_q  <= cfg_wdata[30:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer state and counters.
	state_t              state_q, state_d;
	logic [STEP_W-1:0]   n_q;
	logic [NODE_W-1:0]   j_q;
	logic [STEP_W-1:0]   lvl_q;
	logic [POS_W-1:0]    pos_q;
	logic [31:0]         g_q;
	logic                func_q;
	logic [31:0]         spot_q;
	logic [31:0]         strike_q;
	logic [31:0]         res_q;
	logic                ov_q;
	logic                out_valid_q;
	rsp_t                out_q;

	logic [STEP_W-1:0]   n_in;
	logic [NODE_W-1:0]   two_n;
	logic                up_last;
	logic                down_last;
	logic                ring_last;
	logic [31:0]         mul_a;
	logic [31:0]         mul_f;
	logic [33:0]         mul_p;
	logic [31:0]         mul_sat;
	logic                mul_ov;
	logic                fill_we;
	node_t               fill_node;
	logic [STEP_W-1:0]   k_lvl;
	logic [NODE_W-1:0]   lo, hi;
	logic                out_load;
	dp_ctl_t             dp_ctl;
	dp_res_t             dp_res;

	assign n_in      = (steps_q > 7'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : steps_q[STEP_W-1:0];
	assign two_n     = NODE_W'({n_q, 1'b0});
	assign up_last   = j_q == two_n;
	assign down_last = j_q == '0;
	assign ring_last = pos_q == POS_W'(RING_LEN - 1);

	// One shared multiplier builds the stock prices outward from the middle.
	// On the last up step it already starts the down side from spot.
	always_comb begin
		mul_a = g_q;
		mul_f = {1'b0, down_q};
		if (state_q == ST_UP) begin
			if (up_last) begin
				mul_a = spot_q;
			end else begin
				mul_f = up_q;
			end
		end
	end

	assign mul_p   = mul_q30(mul_a, mul_f);
	assign mul_ov  = mul_p[33:32] != '0;
	assign mul_sat = mul_ov ? '1 : mul_p[31:0];

	assign fill_we         = (state_q == ST_UP) || (state_q == ST_DOWN);
	assign fill_node.price = g_q;
	assign fill_node.value = payoff(func_q, g_q, strike_q);

	// Live window of the current level: nodes n-k through n+k.
	assign k_lvl = lvl_q - STEP_W'(1);
	assign lo    = NODE_W'(n_q) - NODE_W'(k_lvl);
	assign hi    = NODE_W'(n_q) + NODE_W'(k_lvl);

	assign dp_ctl.en   = state_q == ST_INDUCT;
	assign dp_ctl.act  = (pos_q >= POS_W'(lo)) && (pos_q <= POS_W'(hi));
	assign dp_ctl.root = lvl_q == STEP_W'(1);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_UP;
			end
			ST_UP: begin
				if (up_last) state_d = (n_q == '0) ? ST_DONE : ST_DOWN;
			end
			ST_DOWN: begin
				if (down_last) state_d = ST_INDUCT;
			end
			ST_INDUCT: begin
				if (ring_last && lvl_q == STEP_W'(1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_ready  = state_q == ST_IDLE;
		out_valid = out_valid_q;
		out_data  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			j_q         <= '0;
			lvl_q       <= '0;
			pos_q       <= '0;
			ov_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						n_q  <= n_in;
						j_q  <= NODE_W'(n_in);
						ov_q <= 1'b0;
					end
				end
				ST_UP: begin
					if (up_last) begin
						j_q  <= NODE_W'(n_q) - NODE_W'(1);
						ov_q <= ov_q | (mul_ov & (n_q != '0));
					end else begin
						j_q  <= j_q + NODE_W'(1);
						ov_q <= ov_q | mul_ov;
					end
				end
				ST_DOWN: begin
					if (down_last) begin
						lvl_q <= n_q;
						pos_q <= '0;
					end else begin
						j_q  <= j_q - NODE_W'(1);
						ov_q <= ov_q | mul_ov;
					end
				end
				ST_INDUCT: begin
					ov_q <= ov_q | dp_res.ov_hit;
					if (ring_last) begin
						pos_q <= '0;
						lvl_q <= lvl_q - STEP_W'(1);
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q   <= in_data.func;
			spot_q   <= in_data.spot;
			strike_q <= in_data.strike;
			g_q      <= in_data.spot;
		end else if (fill_we) begin
			g_q <= mul_sat;
		end
		// With zero steps the root is the middle terminal node itself.
		if (state_q == ST_UP && j_q == NODE_W'(n_q)) begin
			res_q <= fill_node.value;
		end else if (dp_ctl.en && dp_res.root_hit) begin
			res_q <= dp_res.node.value;
		end
		if (out_load) begin
			out_q.price    <= res_q;
			out_q.overflow <= ov_q;
		end
	end

	// Chain of node cells; the tail cell is fed by the datapath, the head and
	// its neighbor feed the datapath, so one rotation visits every node.
	node_t cell_q [NODES];

	for (genvar i = 0; i < NODES; i++) begin : g_cell
		node_t nxt;
		if (i < NODES - 1) begin : g_mid
			assign nxt = cell_q[i+1];
		end else begin : g_tail
			assign nxt = dp_res.node;
		end
		trp_cell u_cell (
			.clk   (clk),
			.shift (dp_ctl.en),
			.nxt   (nxt),
			.we    (fill_we && (j_q == NODE_W'(i))),
			.wdata (fill_node),
			.q     (cell_q[i])
		);
	end

	trp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (dp_ctl),
		.head      (cell_q[0]),
		.upper     (cell_q[1]),
		.is_put    (func_q),
		.strike    (strike_q),
		.prob_up   (pu_q),
		.prob_mid  (pm_q),
		.prob_down (pd_q),
		.discount  (disc_q),
		.res       (dp_res)
	);

endmodule

// File: sv/trp_checker.sv
// ---------------------------------------------------------------------------
// trp_checker: port-level checks for the option pricer
// Watches the item channels of the top level over time.
// ---------------------------------------------------------------------------
module trp_checker
	import trp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input rsp_t out_data
);

	// A result waiting on a stalled consumer is held.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// Only one item is priced at a time: an accepted item makes the unit busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

	// A new result only appears once pricing has ended, never from idle.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the unit was idle");

	// A fresh result cannot appear in the cycle after an accept.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared without any pricing time");

endmodule

bind trinomial_american_option_pricer_unit trp_checker u_trp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
